// ===== rtl/kvm_pkg.sv =====
// Shared constants, types and codes of the key/value match table.
package kvm_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS    = 64;
  localparam int VALUE_BITS  = 32;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Port field widths
  localparam int MODE_W   = 2;
  localparam int KEY_W    = 64;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP  = 2'd0,
    MODE_INSERT  = 2'd1,
    MODE_REVERSE = 2'd2,
    MODE_REMOVE  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_KEY_MISSING   = 3'd1,
    ST_DUPLICATE     = 3'd2,
    ST_VALUE_MISSING = 3'd3,
    ST_FULL          = 3'd4
  } status_t;

  // Request broadcast to every cell
  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } cmd_t;

  // Per-cell control from the table controller
  typedef struct packed {
    logic occupied;
    logic load;
    logic shift;
  } cell_ctl_t;

  // Search results handed from cell to cell
  typedef struct packed {
    logic                  key_seen;
    logic                  value_seen;
    logic [VALUE_BITS-1:0] value_acc;
    logic [KEY_BITS-1:0]   key_acc;
  } chain_t;

endpackage

// ===== rtl/kvm_if.sv =====
// Request and response channel interfaces of the key/value match table.
interface kvm_req_if import kvm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [KEY_W-1:0]   key_in;
  logic [VALUE_W-1:0] value_in;

  modport source (output valid, mode, key_in, value_in, input ready);
  modport sink   (input valid, mode, key_in, value_in, output ready);
endinterface

interface kvm_rsp_if import kvm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  value_out;
  logic [KEY_W-1:0]    key_out;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, value_out, key_out, entry_count, input ready);
  modport sink   (input valid, status, value_out, key_out, entry_count, output ready);
endinterface

// ===== rtl/kvm_cell.sv =====
// One table entry: holds a pair, compares it and passes search results on.
module kvm_cell import kvm_pkg::*; (
  input  logic                  clk,
  input  cmd_t                  cmd,
  input  cell_ctl_t             ctl,
  input  logic [KEY_BITS-1:0]   up_key,
  input  logic [VALUE_BITS-1:0] up_value,
  input  chain_t                chain_in,
  output chain_t                chain_out,
  output logic [KEY_BITS-1:0]   key,
  output logic [VALUE_BITS-1:0] value
);

  logic key_hit;
  logic value_hit;
  logic first_key;
  logic first_value;

  // Compare against the broadcast request
  assign key_hit     = ctl.occupied && (key == cmd.key);
  assign value_hit   = ctl.occupied && (value == cmd.value);
  assign first_key   = key_hit && !chain_in.key_seen;
  assign first_value = value_hit && !chain_in.value_seen;

  // Pass the earliest hit on to the next cell
  always_comb begin
    chain_out.key_seen   = chain_in.key_seen | key_hit;
    chain_out.value_seen = chain_in.value_seen | value_hit;
    chain_out.value_acc  = chain_in.value_acc | (first_key ? value : '0);
    chain_out.key_acc    = chain_in.key_acc | (first_value ? key : '0);
  end

  // Load a new pair, or take the neighbor's pair at and after the removed slot
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key   <= cmd.key;
      value <= cmd.value;
    end else if (ctl.shift && (chain_in.key_seen || key_hit)) begin
      key   <= up_key;
      value <= up_value;
    end
  end

endmodule

// ===== rtl/key_value_match_table.sv =====
// Top level of the key/value match table: request register, cell row, response register.
//
// An ordered table of up to 16 unique key/value pairs. Each request on req
// carries mode (lookup, insert, reverse lookup, remove), key_in and value_in;
// each request gives exactly one response on rsp with status, value_out,
// key_out and entry_count (entries held after the operation).
// Both channels use valid/ready; a request is taken when both are high.
// A request is captured in an input register, worked by the row of cells once
// the response register can take a result (all cells compare in parallel, a removal
// shifts every later cell down one place at once), and the response is registered.
// Each request thus passes the input register and then the response register.
// Throughput: one request per cycle while rsp.ready stays high.
// When the receiver stalls, the response register holds, one more request
// waits in the input register, and req.ready drops.
// Reset (rst, synchronous) empties the table and both registers; stored pairs
// are not cleared, since only entries below the count are ever compared.
module key_value_match_table import kvm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  kvm_req_if.sink   req,
  kvm_rsp_if.source rsp
);

  // Request register
  logic                  req_valid;
  mode_t                 req_mode;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_value;

  // Table state and response register
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;
  logic                  out_valid;
  status_t               out_status;
  status_t               out_status_next;
  logic [VALUE_W-1:0]    out_value;
  logic [VALUE_W-1:0]    out_value_next;
  logic [KEY_W-1:0]      out_key;
  logic [KEY_W-1:0]      out_key_next;
  logic [COUNT_W-1:0]    out_count;

  logic                  fire;
  logic                  has_room;
  logic                  do_insert;
  logic                  do_remove;
  cmd_t                  cmd;
  chain_t                chain [TABLE_DEPTH+1];
  logic [KEY_BITS-1:0]   cell_key   [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] cell_value [TABLE_DEPTH];

  assign fire      = req_valid && (!out_valid || rsp.ready);
  assign req.ready = !req_valid || fire;

  // Capture a request
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req.ready) begin
      req_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_mode  <= mode_t'(req.mode);
      req_key   <= req.key_in[KEY_BITS-1:0];
      req_value <= req.value_in[VALUE_BITS-1:0];
    end
  end

  assign cmd.key   = req_key;
  assign cmd.value = req_value;

  // Row of cells, chained from entry 0 upward
  assign chain[0] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cell_ctl_t             ctl;
    logic [KEY_BITS-1:0]   up_key;
    logic [VALUE_BITS-1:0] up_value;

    assign ctl.occupied = CNT_W'(i) < cnt;
    assign ctl.load     = do_insert && (cnt == CNT_W'(i));
    assign ctl.shift    = do_remove;

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign up_key   = '0;
      assign up_value = '0;
    end else begin : g_mid
      assign up_key   = cell_key[i+1];
      assign up_value = cell_value[i+1];
    end

    kvm_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .ctl       (ctl),
      .up_key    (up_key),
      .up_value  (up_value),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .key       (cell_key[i]),
      .value     (cell_value[i])
    );
  end

  assign has_room  = cnt != CNT_W'(TABLE_DEPTH);
  assign do_insert = fire && (req_mode == MODE_INSERT) && !chain[TABLE_DEPTH].key_seen
                     && has_room;
  assign do_remove = fire && (req_mode == MODE_REMOVE) && chain[TABLE_DEPTH].key_seen;

  // Decide status, outputs and the new count
  always_comb begin
    out_status_next = ST_OK;
    out_value_next  = '0;
    out_key_next    = '0;
    cnt_next        = cnt;
    case (req_mode)
      MODE_LOOKUP: begin
        if (chain[TABLE_DEPTH].key_seen) begin
          out_value_next = VALUE_W'(chain[TABLE_DEPTH].value_acc);
        end else begin
          out_status_next = ST_KEY_MISSING;
        end
      end
      MODE_INSERT: begin
        if (chain[TABLE_DEPTH].key_seen) begin
          out_status_next = ST_DUPLICATE;
        end else if (!has_room) begin
          out_status_next = ST_FULL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      MODE_REVERSE: begin
        if (chain[TABLE_DEPTH].value_seen) begin
          out_key_next = KEY_W'(chain[TABLE_DEPTH].key_acc);
        end else begin
          out_status_next = ST_VALUE_MISSING;
        end
      end
      MODE_REMOVE: begin
        if (chain[TABLE_DEPTH].key_seen) begin
          cnt_next = cnt - 1'b1;
        end else begin
          out_status_next = ST_KEY_MISSING;
        end
      end
      default: begin
        out_status_next = ST_OK;
      end
    endcase
  end

  // Advance the count and load the response
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        cnt <= cnt_next;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= out_status_next;
      out_value  <= out_value_next;
      out_key    <= out_key_next;
      out_count  <= COUNT_W'(cnt_next);
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.value_out   = out_value;
  assign rsp.key_out     = out_key;
  assign rsp.entry_count = out_count;

endmodule
